### rtl/lz4d_pkg.sv
// ----------------------------------------------------------------------------
// LZ4 block decoder package
// Shared item types, status codes and parse phases.
// ----------------------------------------------------------------------------
package lz4d_pkg;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_valid;
    logic        block_end;
    logic [2:0]  status;
    logic [31:0] produced;
  } result_t;

  typedef struct packed {
    logic pop;
  } queue_ctl_t;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_TRUNC      = 3'd1;
  localparam logic [2:0] ST_OFFSET     = 3'd2;
  localparam logic [2:0] ST_OVERFLOW   = 3'd3;
  localparam logic [2:0] ST_UNEXPECTED = 3'd4;

  localparam logic       OP_BYTE = 1'b0;
  localparam logic       OP_TICK = 1'b1;

  localparam logic [31:0] CAPACITY_RESET = 32'd65536;

  typedef enum logic [7:0] {
    PH_TOKEN  = 8'b0000_0001,
    PH_LITEXT = 8'b0000_0010,
    PH_LIT    = 8'b0000_0100,
    PH_OFFLO  = 8'b0000_1000,
    PH_OFFHI  = 8'b0001_0000,
    PH_MATEXT = 8'b0010_0000,
    PH_COPY   = 8'b0100_0000,
    PH_DRAIN  = 8'b1000_0000
  } phase_t;

endpackage

### rtl/lz4d_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module lz4d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/lz4d_front.sv
// ----------------------------------------------------------------------------
// LZ4 decoder front
// Accepts requests into a two-entry queue that decouples the parser.
// ----------------------------------------------------------------------------
module lz4d_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  lz4d_pkg::item_t      req,
  output lz4d_pkg::item_t      head,
  input  lz4d_pkg::queue_ctl_t ctl_in,
  output logic                 head_valid
);
  import lz4d_pkg::*;

  item_t      entry [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign req_stall  = (count == 2'd2);
  assign push       = req_valid && !req_stall;
  assign pop        = ctl_in.pop && (count != 2'd0);
  assign head_valid = (count != 2'd0);
  assign head       = entry[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wp] <= req;
    end
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### rtl/lz4d_back.sv
// ----------------------------------------------------------------------------
// LZ4 decoder back end
// Sequence parser, history memory, result stage and output register.
// ----------------------------------------------------------------------------
module lz4d_back #(
  parameter int HISTORY_DEPTH = 65536
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_data,
  input  lz4d_pkg::item_t      head,
  input  logic                 head_valid,
  output lz4d_pkg::queue_ctl_t ctl_out,
  output logic                 res_valid,
  input  logic                 res_stall,
  output lz4d_pkg::result_t    res
);
  import lz4d_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_W   = (AW+1)'(HISTORY_DEPTH);

  logic [31:0] capacity;
  phase_t      phase, phase_next;
  logic [31:0] lit_rem, lit_rem_next;
  logic [3:0]  nib, nib_next;
  logic [31:0] mat_rem, mat_rem_next;
  logic [15:0] offset, offset_next;
  logic [31:0] bw, bw_next;
  logic        ends, ends_next;
  logic [AW-1:0] wptr, wptr_next;

  logic        adv;
  logic        take;
  logic [31:0] room;
  logic [AW:0] rd_diff;
  logic [AW-1:0] rd_ptr;

  logic        r_res, r_be, r_we, r_copy;
  logic [2:0]  r_st;
  logic [31:0] r_prod;

  logic        b_vld, b_be, b_we, b_copy, b_hit;
  logic [2:0]  b_st;
  logic [31:0] b_prod;
  logic [7:0]  b_lit, b_byp, b_byte;
  logic [AW-1:0] b_waddr;
  logic [7:0]  rdata;

  logic        out_v;
  result_t     out_r;

  always_comb begin
    logic        go_lit, go_after, go_copy, fin, fin_last;
    logic [2:0]  fin_st;
    logic [31:0] len_l, len_m, l_dec, m_dec;
    logic [32:0] lit_sum, mat_sum;
    logic [33:0] mat_sum4;
    logic [15:0] off_full;
    logic [7:0]  b;
    logic        last;

    b        = head.data_byte;
    last     = head.last;
    go_lit   = 1'b0;
    go_after = 1'b0;
    go_copy  = 1'b0;
    fin      = 1'b0;
    fin_last = last;
    fin_st   = ST_OK;
    phase_next   = phase;
    lit_rem_next = lit_rem;
    nib_next     = nib;
    mat_rem_next = mat_rem;
    offset_next  = offset;
    bw_next      = bw;
    ends_next    = ends;
    wptr_next    = wptr;
    r_res  = 1'b0;
    r_be   = 1'b0;
    r_st   = ST_OK;
    r_we   = 1'b0;
    r_copy = 1'b0;

    lit_sum  = {1'b0, lit_rem} + {25'd0, b};
    mat_sum  = {1'b0, mat_rem} + {25'd0, b};
    mat_sum4 = {2'b00, mat_rem} + {26'd0, b} + 34'd4;
    off_full = {b, offset[7:0]};
    l_dec    = lit_rem - 32'd1;
    m_dec    = mat_rem - 32'd1;
    len_l    = lit_sum[32] ? 32'hFFFF_FFFF : lit_sum[31:0];
    len_m    = (mat_sum4[33:32] != 2'b00) ? 32'hFFFF_FFFF : mat_sum4[31:0];

    if (head_valid) begin
      if (head.op == OP_TICK) begin
        if (phase == PH_COPY) begin
          r_we   = 1'b1;
          r_copy = 1'b1;
          r_res  = 1'b1;
          mat_rem_next = m_dec;
          if (m_dec == 32'd0) begin
            if (ends) begin
              fin      = 1'b1;
              fin_last = 1'b1;
            end else begin
              phase_next = PH_TOKEN;
            end
          end
        end
      end else begin
        unique case (phase)
          PH_TOKEN: begin
            nib_next     = b[3:0];
            lit_rem_next = {28'd0, b[7:4]};
            len_l        = {28'd0, b[7:4]};
            if (b[7:4] == 4'hF) begin
              if (last) begin
                fin    = 1'b1;
                fin_st = ST_TRUNC;
              end else begin
                phase_next = PH_LITEXT;
              end
            end else begin
              go_lit = 1'b1;
            end
          end
          PH_LITEXT: begin
            lit_rem_next = len_l;
            if (b == 8'hFF) begin
              if (last) begin
                fin    = 1'b1;
                fin_st = ST_TRUNC;
              end
            end else begin
              go_lit = 1'b1;
            end
          end
          PH_LIT: begin
            r_we         = 1'b1;
            r_res        = 1'b1;
            lit_rem_next = l_dec;
            if (l_dec == 32'd0) begin
              go_after = 1'b1;
            end else if (last) begin
              fin    = 1'b1;
              fin_st = ST_TRUNC;
            end
          end
          PH_OFFLO: begin
            offset_next = {8'd0, b};
            if (last) begin
              fin    = 1'b1;
              fin_st = ST_TRUNC;
            end else begin
              phase_next = PH_OFFHI;
            end
          end
          PH_OFFHI: begin
            offset_next = off_full;
            if (off_full == 16'd0 || {16'd0, off_full} > bw) begin
              fin    = 1'b1;
              fin_st = ST_OFFSET;
            end else if (nib == 4'hF) begin
              if (last) begin
                fin    = 1'b1;
                fin_st = ST_TRUNC;
              end else begin
                mat_rem_next = 32'd15;
                phase_next   = PH_MATEXT;
              end
            end else begin
              len_m   = {28'd0, nib} + 32'd4;
              go_copy = 1'b1;
            end
          end
          PH_MATEXT: begin
            if (b == 8'hFF) begin
              mat_rem_next = mat_sum[32] ? 32'hFFFF_FFFF : mat_sum[31:0];
              if (last) begin
                fin    = 1'b1;
                fin_st = ST_TRUNC;
              end
            end else begin
              go_copy = 1'b1;
            end
          end
          PH_COPY: begin
            fin    = 1'b1;
            fin_st = ST_UNEXPECTED;
          end
          PH_DRAIN: begin
            if (last) begin
              phase_next = PH_TOKEN;
            end
          end
          default: begin
            phase_next = PH_TOKEN;
          end
        endcase
      end

      if (go_lit) begin
        if (len_l == 32'd0) begin
          go_after = 1'b1;
        end else if (last) begin
          fin    = 1'b1;
          fin_st = ST_TRUNC;
        end else if (len_l > room) begin
          fin      = 1'b1;
          fin_st   = ST_OVERFLOW;
          fin_last = 1'b0;
        end else begin
          phase_next   = PH_LIT;
          lit_rem_next = len_l;
        end
      end

      if (go_after) begin
        if (last) begin
          fin    = 1'b1;
          fin_st = (nib_next == 4'd0) ? ST_OK : ST_TRUNC;
        end else begin
          phase_next = PH_OFFLO;
        end
      end

      if (go_copy) begin
        if (len_m > room) begin
          fin    = 1'b1;
          fin_st = ST_OVERFLOW;
        end else begin
          phase_next   = PH_COPY;
          mat_rem_next = len_m;
          ends_next    = last;
        end
      end

      if (r_we) begin
        bw_next   = bw + 32'd1;
        wptr_next = (wptr == LAST_ADDR) ? '0 : wptr + AW'(1);
      end
      r_prod = bw_next;

      if (fin) begin
        r_res        = 1'b1;
        r_be         = 1'b1;
        r_st         = fin_st;
        phase_next   = (fin_st != ST_OK && !fin_last) ? PH_DRAIN : PH_TOKEN;
        lit_rem_next = '0;
        nib_next     = '0;
        mat_rem_next = '0;
        offset_next  = '0;
        bw_next      = '0;
        ends_next    = 1'b0;
        wptr_next    = '0;
      end
    end else begin
      r_prod = bw;
    end
  end

  assign room    = (capacity > bw) ? capacity - bw : 32'd0;
  assign rd_diff = ({1'b0, wptr} >= {{(AW-15){1'b0}}, offset})
                 ? {1'b0, wptr} - {{(AW-15){1'b0}}, offset}
                 : {1'b0, wptr} + DEPTH_W - {{(AW-15){1'b0}}, offset};
  assign rd_ptr  = rd_diff[AW-1:0];

  assign adv   = !out_v || !res_stall;
  assign take  = adv && head_valid;
  assign ctl_out.pop = take;

  assign b_byte = b_copy ? (b_hit ? b_byp : rdata) : b_lit;

  lz4d_ram #(
    .WIDTH(8),
    .DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (adv && b_vld && b_we),
    .waddr(b_waddr),
    .wdata(b_byte),
    .re   (adv),
    .raddr(rd_ptr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      b_be    <= r_be;
      b_st    <= r_st;
      b_we    <= r_we;
      b_copy  <= r_copy;
      b_prod  <= r_prod;
      b_lit   <= head.data_byte;
      b_waddr <= wptr;
      b_hit   <= b_vld && b_we && (b_waddr == rd_ptr);
      b_byp   <= b_byte;
      if (b_vld) begin
        out_r.out_byte  <= b_we ? b_byte : 8'd0;
        out_r.out_valid <= b_we;
        out_r.block_end <= b_be;
        out_r.status    <= b_st;
        out_r.produced  <= b_prod;
      end
    end
    if (rst) begin
      capacity <= CAPACITY_RESET;
      phase    <= PH_TOKEN;
      lit_rem  <= '0;
      nib      <= '0;
      mat_rem  <= '0;
      offset   <= '0;
      bw       <= '0;
      ends     <= 1'b0;
      wptr     <= '0;
      b_vld    <= 1'b0;
      out_v    <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      if (take) begin
        phase   <= phase_next;
        lit_rem <= lit_rem_next;
        nib     <= nib_next;
        mat_rem <= mat_rem_next;
        offset  <= offset_next;
        bw      <= bw_next;
        ends    <= ends_next;
        wptr    <= wptr_next;
      end
      if (adv) begin
        b_vld <= take && r_res;
        out_v <= b_vld;
      end
    end
  end

  assign res_valid = out_v;
  assign res       = out_r;

endmodule

### rtl/lz4_block_decoder.sv
// ----------------------------------------------------------------------------
// LZ4 block decoder
// Decodes a raw LZ4 block one compressed byte or copy tick per request.
// ----------------------------------------------------------------------------
// The decoder takes one request per cycle while req_stall is low and returns
// at most one result per request. A request passes through a two-entry
// queue, the sequence parser with its history memory read, and the
// output register. Matches are copied one byte per tick request from a
// history memory of HISTORY_DEPTH bytes; a copy with offset one is served by
// a bypass of the byte being written. The history needs no clearing after
// reset, since offsets are checked against the bytes written in the block.
module lz4_block_decoder #(
  parameter int HISTORY_DEPTH = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_data,
  input  logic              req_valid,
  output logic              req_stall,
  input  lz4d_pkg::item_t   req,
  output logic              res_valid,
  input  logic              res_stall,
  output lz4d_pkg::result_t res
);
  import lz4d_pkg::*;

  item_t      head;
  logic       head_valid;
  queue_ctl_t ctl;

  lz4d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .head      (head),
    .ctl_in    (ctl),
    .head_valid(head_valid)
  );

  lz4d_back #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .head      (head),
    .head_valid(head_valid),
    .ctl_out   (ctl),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  a_status_only_at_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.block_end |-> res.status == ST_OK)
    else $error("status set without block end");

  a_byte_zero_when_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.out_valid |-> res.out_byte == 8'd0)
    else $error("out_byte set without a decoded byte");

  a_produced_counts: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.out_valid |-> res.produced != 32'd0)
    else $error("decoded byte with zero produced count");

endmodule
